### rtl/vmwm_pkg.sv
package vmwm_pkg;

  localparam int DEF_MAX_ROWS   = 32;
  localparam int DEF_MAX_COLS   = 32;
  localparam int DEF_MAX_LAYERS = 32;
  localparam int DEF_MAX_KERNEL = 4;

  localparam int COORD_W   = 5;
  localparam int VOXEL_W   = 8;
  localparam int RES_W     = 8;
  localparam int IN_DATA_W = 24;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int KSIZE_W   = 3;
  localparam int EXT_W     = 6;
  // clamped extents go up to 32 at the default maxima
  localparam int EXTC_W    = 9;
  localparam int BIT_IDX_W = 6;

  localparam logic [RES_W-1:0] RES_FALSE     = 8'h00;
  localparam logic [RES_W-1:0] RES_TRUE      = 8'h01;
  localparam logic [RES_W-1:0] RES_TRUE_GRAY = 8'hff;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;
  localparam logic MODE_ALL  = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_BITS  = 3'd0,
    REG_MASK_BITS    = 3'd1,
    REG_KERNEL_SIZE  = 3'd2,
    REG_COMBINE_MODE = 3'd3,
    REG_GRAY_OUTPUT  = 3'd4,
    REG_IMAGE_ROWS   = 3'd5,
    REG_IMAGE_COLS   = 3'd6,
    REG_IMAGE_LAYERS = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } ctl_state_e;

  typedef struct packed {
    logic [CFG_W-1:0]   kernel_bits;
    logic [CFG_W-1:0]   mask_bits;
    logic [KSIZE_W-1:0] kernel_size;
    logic               combine_mode;
    logic               gray_output;
    logic [EXT_W-1:0]   image_rows;
    logic [EXT_W-1:0]   image_cols;
    logic [EXT_W-1:0]   image_layers;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic issue_write;
    logic issue_query;
    logic load_result;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_query;
    logic in_img;
    logic ks_zero;
    logic scan_last;
    logic pipe_busy;
    logic out_free;
  } ctl_sts_t;

endpackage

### rtl/volume_morphology_window_match_core.sv
// Write transaction: the voxel passes the product and address stages before it lands in memory;
// the next transaction may be taken meanwhile. Query: the single-port volume memory is read once
// per window position, the pipeline drains and the result goes to the output register, then the
// next transaction is taken. Out-of-image query or zero kernel: the scan is skipped.
// A waiting result does not hold the input; the next query waits for the output register.
// Reset (rst_ni low, asynchronous) clears control and config; volume memory needs no clearing.
module volume_morphology_window_match_core
  import vmwm_pkg::*;
#(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_LAYERS = DEF_MAX_LAYERS,
  parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,  // row, col, layer, voxel_value, pad
  input  logic                 s_axis_tuser,  // cmd
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [RES_W-1:0]     m_axis_tdata   // result_value
);

  cfg_t     cfg;
  ctl_cmd_t cmd;
  ctl_sts_t sts;

  vmwm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  vmwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vmwm_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_LAYERS (MAX_LAYERS),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .out_tready_i (m_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_tdata_o  (m_axis_tdata)
  );

endmodule

### rtl/vmwm_ram.sv
module vmwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### rtl/vmwm_cfg.sv
module vmwm_cfg
  import vmwm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [CFG_IDX_W-1:0] idx_i,
  input  logic [CFG_W-1:0]     wdata_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (reg_idx_e'(idx_i))
        REG_KERNEL_BITS:  cfg_d.kernel_bits  = wdata_i;
        REG_MASK_BITS:    cfg_d.mask_bits    = wdata_i;
        REG_KERNEL_SIZE:  cfg_d.kernel_size  = wdata_i[KSIZE_W-1:0];
        REG_COMBINE_MODE: cfg_d.combine_mode = wdata_i[0];
        REG_GRAY_OUTPUT:  cfg_d.gray_output  = wdata_i[0];
        REG_IMAGE_ROWS:   cfg_d.image_rows   = wdata_i[EXT_W-1:0];
        REG_IMAGE_COLS:   cfg_d.image_cols   = wdata_i[EXT_W-1:0];
        REG_IMAGE_LAYERS: cfg_d.image_layers = wdata_i[EXT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kernel_bits  <= '0;
      cfg_q.mask_bits    <= '0;
      cfg_q.kernel_size  <= KSIZE_W'(3);
      cfg_q.combine_mode <= 1'b0;
      cfg_q.gray_output  <= 1'b0;
      cfg_q.image_rows   <= EXT_W'(32);
      cfg_q.image_cols   <= EXT_W'(32);
      cfg_q.image_layers <= EXT_W'(32);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/vmwm_ctrl.sv
module vmwm_ctrl
  import vmwm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (!sts_i.is_query)                  state_d = ST_IDLE;
        else if (!sts_i.in_img || sts_i.ks_zero)       state_d = ST_RESULT;
        else                                           state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DECODE: cmd_o.issue_write = !sts_i.is_query;
      ST_SCAN:   cmd_o.issue_query = 1'b1;
      ST_DRAIN:  ;
      ST_RESULT: cmd_o.load_result = sts_i.out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/vmwm_dp.sv
module vmwm_dp
  import vmwm_pkg::*;
#(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_LAYERS = DEF_MAX_LAYERS,
  parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  ctl_cmd_t             cmd_i,
  output ctl_sts_t             sts_o,
  input  logic [IN_DATA_W-1:0] in_tdata_i,
  input  logic                 in_tuser_i,
  input  logic                 out_tready_i,
  output logic                 out_tvalid_o,
  output logic [RES_W-1:0]     out_tdata_o
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int LW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int ZY_N  = MAX_LAYERS * MAX_ROWS;
  localparam int ZYW   = (ZY_N > 1) ? $clog2(ZY_N) : 1;
  localparam int DEPTH = ZY_N * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int WIN_N = MAX_KERNEL * MAX_KERNEL * MAX_KERNEL;
  localparam int BW    = (WIN_N > 1) ? $clog2(WIN_N) : 1;

  // captured item
  logic               cmd_q;
  logic [COORD_W-1:0] row_q, col_q, lay_q;
  logic [VOXEL_W-1:0] vox_q;

  // clamped extents and kernel side
  logic [EXTC_W-1:0]  nr, nc, nl;
  logic [KSIZE_W-1:0] ks;
  logic [1:0]         half, off;
  logic               in_img;

  always_comb begin
    nr = (EXTC_W'(cfg_i.image_rows) > EXTC_W'(MAX_ROWS)) ?
         EXTC_W'(MAX_ROWS) : EXTC_W'(cfg_i.image_rows);
    nc = (EXTC_W'(cfg_i.image_cols) > EXTC_W'(MAX_COLS)) ?
         EXTC_W'(MAX_COLS) : EXTC_W'(cfg_i.image_cols);
    nl = (EXTC_W'(cfg_i.image_layers) > EXTC_W'(MAX_LAYERS)) ?
         EXTC_W'(MAX_LAYERS) : EXTC_W'(cfg_i.image_layers);
    ks = (cfg_i.kernel_size > KSIZE_W'(MAX_KERNEL)) ?
         KSIZE_W'(MAX_KERNEL) : cfg_i.kernel_size;
    half   = ks[2:1];
    in_img = (EXTC_W'(row_q) < nr) && (EXTC_W'(col_q) < nc) && (EXTC_W'(lay_q) < nl);
  end

  // window counters
  logic [KW-1:0] wl_q, wr_q, wc_q, wl_d, wr_d, wc_d, kmax;
  logic [BW-1:0] bit_q, bit_d;
  logic          last_c, last_r, scan_last;

  always_comb begin
    kmax      = KW'(ks - KSIZE_W'(1));
    last_c    = (wc_q == kmax);
    last_r    = (wr_q == kmax);
    scan_last = last_c && last_r && (wl_q == kmax);
    wl_d  = wl_q;
    wr_d  = wr_q;
    wc_d  = wc_q;
    bit_d = bit_q;
    priority if (cmd_i.capture) begin
      wl_d  = '0;
      wr_d  = '0;
      wc_d  = '0;
      bit_d = '0;
    end else if (cmd_i.issue_query) begin
      bit_d = bit_q + BW'(1);
      wc_d  = last_c ? '0 : wc_q + KW'(1);
      if (last_c) begin
        wr_d = last_r ? '0 : wr_q + KW'(1);
        if (last_r) wl_d = wl_q + KW'(1);
      end
    end else begin
    end
  end

  // issue: window coordinate and enable
  logic [7:0] zs, ys, xs;
  logic       issue, pos_in, pos_en, pos_kb;

  always_comb begin
    issue  = cmd_i.issue_write || cmd_i.issue_query;
    off    = cmd_i.issue_query ? half : 2'd0;
    zs     = 8'(lay_q) + 8'(wl_q) - 8'(off);
    ys     = 8'(row_q) + 8'(wr_q) - 8'(off);
    xs     = 8'(col_q) + 8'(wc_q) - 8'(off);
    pos_in = !zs[7] && (EXTC_W'(zs) < nl) && !ys[7] && (EXTC_W'(ys) < nr) &&
             !xs[7] && (EXTC_W'(xs) < nc);
    pos_en = pos_in && (cmd_i.issue_write || cfg_i.mask_bits[BIT_IDX_W'(bit_q)]);
    pos_kb = cfg_i.kernel_bits[BIT_IDX_W'(bit_q)];
  end

  // stage 1: layer/row product
  logic               s1_v_q, s1_en_q, s1_we_q, s1_kb_q;
  logic [ZYW-1:0]     s1_zy_q;
  logic [CW-1:0]      s1_x_q;
  logic [VOXEL_W-1:0] s1_wd_q;
  // stage 2: address
  logic               s2_v_q, s2_en_q, s2_we_q, s2_kb_q;
  logic [AW-1:0]      s2_addr_q;
  logic [VOXEL_W-1:0] s2_wd_q;
  // stage 3: read data
  logic               s3_v_q, s3_kb_q;
  logic [VOXEL_W-1:0] rdata;
  logic               ram_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q && s2_en_q && !s2_we_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_en_q   <= pos_en;
    s1_we_q   <= cmd_i.issue_write;
    s1_kb_q   <= pos_kb;
    s1_zy_q   <= ZYW'(zs[LW-1:0]) * ZYW'(MAX_ROWS) + ZYW'(ys[RW-1:0]);
    s1_x_q    <= xs[CW-1:0];
    s1_wd_q   <= vox_q;
    s2_en_q   <= s1_en_q;
    s2_we_q   <= s1_we_q;
    s2_kb_q   <= s1_kb_q;
    s2_addr_q <= AW'(s1_zy_q) * AW'(MAX_COLS) + AW'(s1_x_q);
    s2_wd_q   <= s1_wd_q;
    s3_kb_q   <= s2_kb_q;
  end

  assign ram_we = s2_v_q && s2_en_q && s2_we_q;

  vmwm_ram #(
    .WIDTH (VOXEL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (s2_addr_q),
    .wdata_i (s2_wd_q),
    .rdata_o (rdata)
  );

  // accumulate
  logic acc_q, acc_d, match;

  always_comb begin
    match = (rdata == VOXEL_W'(s3_kb_q));
    acc_d = acc_q;
    priority if (cmd_i.capture) begin
      acc_d = (cfg_i.combine_mode == MODE_ALL);
    end else if (s3_v_q) begin
      acc_d = (cfg_i.combine_mode == MODE_ALL) ? (acc_q && match) : (acc_q || match);
    end else begin
    end
  end

  // output register
  logic             out_v_q, out_v_d;
  logic [RES_W-1:0] out_q, out_d;

  always_comb begin
    out_v_d = out_v_q;
    out_d   = out_q;
    priority if (cmd_i.load_result) begin
      out_v_d = 1'b1;
      out_d   = (in_img && acc_q) ? (cfg_i.gray_output ? RES_TRUE_GRAY : RES_TRUE) :
                RES_FALSE;
    end else if (out_tready_i) begin
      out_v_d = 1'b0;
    end else begin
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      wl_q    <= '0;
      wr_q    <= '0;
      wc_q    <= '0;
      bit_q   <= '0;
    end else begin
      out_v_q <= out_v_d;
      wl_q    <= wl_d;
      wr_q    <= wr_d;
      wc_q    <= wc_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    acc_q <= acc_d;
    if (cmd_i.capture) begin
      cmd_q <= in_tuser_i;
      row_q <= in_tdata_i[4:0];
      col_q <= in_tdata_i[9:5];
      lay_q <= in_tdata_i[14:10];
      vox_q <= in_tdata_i[22:15];
    end
  end

  always_comb begin
    sts_o.is_query  = (cmd_q == CMD_QUERY);
    sts_o.in_img    = in_img;
    sts_o.ks_zero   = (ks == '0);
    sts_o.scan_last = scan_last;
    sts_o.pipe_busy = s1_v_q || s2_v_q || s3_v_q;
    sts_o.out_free  = !out_v_q || out_tready_i;
  end

  assign out_tvalid_o = out_v_q;
  assign out_tdata_o  = out_q;

endmodule

### rtl/vmwm_checker.sv
module vmwm_checker
  import vmwm_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [IN_DATA_W-1:0] s_axis_tdata,
  input logic                 s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [RES_W-1:0]     m_axis_tdata
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_out_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata == RES_FALSE) || (m_axis_tdata == RES_TRUE) ||
                      (m_axis_tdata == RES_TRUE_GRAY))
    else $error("result code out of set");

  // ready drops after each accepted input transaction
  a_in_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // waiting input transaction holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("input changed while waiting");

  a_rst_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid out of reset");

endmodule

bind volume_morphology_window_match_core vmwm_checker u_vmwm_checker (.*);

### tb/tb_volume_morphology_window_match_core.sv
`timescale 1ns / 100ps

module tb_volume_morphology_window_match_core;
  import vmwm_pkg::*;

  localparam int   STORE_DEPTH   = DEF_MAX_ROWS * DEF_MAX_COLS * DEF_MAX_LAYERS;
  localparam int   SETTLE_CYCLES = 80;
  localparam logic MODE_ANY      = ~MODE_ALL;
  localparam logic GRAY_OFF      = 1'b0;
  localparam logic GRAY_ON       = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] layer;
    logic [VOXEL_W-1:0] value;
  } voxel_cmd_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata  = '0;  // row, col, layer, voxel_value, pad
  logic                 s_axis_tuser  = 1'b0;  // cmd
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [RES_W-1:0]     m_axis_tdata;  // result_value

  volume_morphology_window_match_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the block's registers and volume
  logic [CFG_W-1:0]   km_kernel = '0;
  logic [CFG_W-1:0]   km_mask   = '0;
  logic [KSIZE_W-1:0] km_ksize  = 3'd3;
  logic               km_mode   = MODE_ALL;
  logic               km_gray   = GRAY_OFF;
  logic [EXT_W-1:0]   km_ext [3] = '{6'd32, 6'd32, 6'd32};

  logic [VOXEL_W-1:0] shadow_store  [STORE_DEPTH];
  bit                 store_written [STORE_DEPTH];

  voxel_cmd_t       voxel_cmd_q[$];
  logic [RES_W-1:0] morph_expect_q[$];
  voxel_cmd_t       bus_cmd;
  logic [RES_W-1:0] want_res;

  int idle_pct;
  int send_gap;
  int stall_left;
  int hot_base [3];
  int hot_span [3];
  int err_cnt;
  int txn_cnt;
  int fill_cnt;
  int res_cnt;
  int true_cnt;
  int cfg_cnt;

  function automatic int sat_ext(input logic [EXT_W-1:0] e, input int lim);
    return (int'(e) > lim) ? lim : int'(e);
  endfunction

  function automatic int store_addr(input int r, input int c, input int l);
    return (l * DEF_MAX_ROWS + r) * DEF_MAX_COLS + c;
  endfunction

  function automatic bit in_image(input int r, input int c, input int l);
    return r < sat_ext(km_ext[0], DEF_MAX_ROWS) && c < sat_ext(km_ext[1], DEF_MAX_COLS) &&
           l < sat_ext(km_ext[2], DEF_MAX_LAYERS);
  endfunction

  // store entries a query compares, with their window bit positions
  function automatic bit window_reads(input int r, input int c, input int l,
                                      output int addr_q[$], output int pos_q[$]);
    int nr, nc, nl, ks, half, y, x, z, pos;
    addr_q = {};
    pos_q  = {};
    if (!in_image(r, c, l)) return 1'b0;
    nr   = sat_ext(km_ext[0], DEF_MAX_ROWS);
    nc   = sat_ext(km_ext[1], DEF_MAX_COLS);
    nl   = sat_ext(km_ext[2], DEF_MAX_LAYERS);
    ks   = (int'(km_ksize) > DEF_MAX_KERNEL) ? DEF_MAX_KERNEL : int'(km_ksize);
    half = ks / 2;
    for (int wl = 0; wl < ks; wl++) begin
      for (int wr = 0; wr < ks; wr++) begin
        for (int wc = 0; wc < ks; wc++) begin
          z   = l - half + wl;
          y   = r - half + wr;
          x   = c - half + wc;
          pos = (wl * ks + wr) * ks + wc;
          if (z >= 0 && z < nl && y >= 0 && y < nr && x >= 0 && x < nc && km_mask[pos]) begin
            addr_q.push_back(store_addr(y, x, z));
            pos_q.push_back(pos);
          end
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [RES_W-1:0] predict_morphology(input int r, input int c, input int l);
    int   addr_q[$];
    int   pos_q[$];
    logic acc;
    logic hit;
    if (!window_reads(r, c, l, addr_q, pos_q)) return RES_FALSE;
    acc = (km_mode == MODE_ALL);
    foreach (addr_q[i]) begin
      hit = (shadow_store[addr_q[i]] == {7'd0, km_kernel[pos_q[i]]});
      acc = (km_mode == MODE_ALL) ? (acc & hit) : (acc | hit);
    end
    return acc ? (km_gray ? RES_TRUE_GRAY : RES_TRUE) : RES_FALSE;
  endfunction

  function automatic void apply_transaction(input voxel_cmd_t t);
    if (t.cmd == CMD_STORE) begin
      if (in_image(int'(t.row), int'(t.col), int'(t.layer)))
        shadow_store[store_addr(int'(t.row), int'(t.col), int'(t.layer))] = t.value;
    end else begin
      morph_expect_q.push_back(predict_morphology(int'(t.row), int'(t.col), int'(t.layer)));
    end
    txn_cnt++;
  endfunction

  function automatic logic [VOXEL_W-1:0] rand_voxel();
    case ($urandom_range(0, 9))
      0:          return 8'($urandom_range(0, 255));
      1:          return 8'hff;
      2, 3, 4, 5: return 8'h00;
      default:    return 8'h01;
    endcase
  endfunction

  function automatic int pick_coord(input int ax);
    if ($urandom_range(0, 99) < 8) return int'($urandom_range(0, 31));
    return hot_base[ax] + int'($urandom_range(0, hot_span[ax]));
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= CMD_STORE;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_transaction(bus_cmd);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (voxel_cmd_q.size() != 0 && idle_pct != 0 &&
                     $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(0, 8);
          s_axis_tvalid <= 1'b0;
        end else if (voxel_cmd_q.size() != 0) begin
          bus_cmd = voxel_cmd_q.pop_front();
          s_axis_tdata  <= {1'b0, bus_cmd.value, bus_cmd.layer, bus_cmd.col, bus_cmd.row};
          s_axis_tuser  <= bus_cmd.cmd;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (morph_expect_q.size() == 0) begin
          $display("%0t: unexpected result transaction, actual %0d", $time, m_axis_tdata);
          err_cnt++;
        end else begin
          want_res = morph_expect_q.pop_front();
          if (want_res != RES_FALSE) true_cnt++;
          if (m_axis_tdata !== want_res) begin
            $display("%0t: result_value mismatch: expected %0d, actual %0d",
                     $time, want_res, m_axis_tdata);
            err_cnt++;
          end
        end
        res_cnt++;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 8);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic set_reg(input reg_idx_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_KERNEL_BITS:  km_kernel = val;
      REG_MASK_BITS:    km_mask   = val;
      REG_KERNEL_SIZE:  km_ksize  = val[KSIZE_W-1:0];
      REG_COMBINE_MODE: km_mode   = val[0];
      REG_GRAY_OUTPUT:  km_gray   = val[0];
      REG_IMAGE_ROWS:   km_ext[0] = val[EXT_W-1:0];
      REG_IMAGE_COLS:   km_ext[1] = val[EXT_W-1:0];
      REG_IMAGE_LAYERS: km_ext[2] = val[EXT_W-1:0];
    endcase
    cfg_cnt++;
  endtask

  task automatic apply_cfg(input logic [CFG_W-1:0] kern, input logic [CFG_W-1:0] msk,
                           input logic [KSIZE_W-1:0] ks, input logic mode, input logic gray,
                           input logic [EXT_W-1:0] rows, input logic [EXT_W-1:0] cols,
                           input logic [EXT_W-1:0] layers);
    set_reg(REG_KERNEL_BITS, kern);
    set_reg(REG_MASK_BITS, msk);
    set_reg(REG_KERNEL_SIZE, 64'(ks));
    set_reg(REG_COMBINE_MODE, 64'(mode));
    set_reg(REG_GRAY_OUTPUT, 64'(gray));
    set_reg(REG_IMAGE_ROWS, 64'(rows));
    set_reg(REG_IMAGE_COLS, 64'(cols));
    set_reg(REG_IMAGE_LAYERS, 64'(layers));
  endtask

  task automatic push_write(input int r, input int c, input int l, input logic [VOXEL_W-1:0] v);
    voxel_cmd_q.push_back('{cmd: CMD_STORE, row: r[4:0], col: c[4:0], layer: l[4:0], value: v});
    if (in_image(r, c, l)) store_written[store_addr(r, c, l)] = 1'b1;
  endtask

  // a query is preceded by stores to any compared window voxel not yet written
  task automatic push_query(input int r, input int c, input int l);
    int addr_q[$];
    int pos_q[$];
    int a;
    if (window_reads(r, c, l, addr_q, pos_q)) begin
      foreach (addr_q[i]) begin
        a = addr_q[i];
        if (!store_written[a]) begin
          push_write((a / DEF_MAX_COLS) % DEF_MAX_ROWS, a % DEF_MAX_COLS,
                     a / (DEF_MAX_COLS * DEF_MAX_ROWS), rand_voxel());
          fill_cnt++;
        end
      end
    end
    voxel_cmd_q.push_back('{cmd: CMD_QUERY, row: r[4:0], col: c[4:0], layer: l[4:0],
                            value: 8'($urandom_range(0, 255))});
  endtask

  task automatic settle_block();
    @(posedge clk_i);
    while (voxel_cmd_q.size() != 0 || s_axis_tvalid || morph_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_items(input int n);
    int ext;
    for (int ax = 0; ax < 3; ax++) begin
      ext = sat_ext(km_ext[ax], DEF_MAX_ROWS);
      if (ext <= 8) begin
        hot_base[ax] = 0;
        hot_span[ax] = ext;
      end else begin
        hot_base[ax] = $urandom_range(0, ext - 5);
        hot_span[ax] = 4;
      end
    end
    repeat (n) begin
      if ($urandom_range(0, 1) == 1) push_query(pick_coord(0), pick_coord(1), pick_coord(2));
      else push_write(pick_coord(0), pick_coord(1), pick_coord(2), rand_voxel());
    end
    settle_block();
  endtask

  task automatic random_cfg();
    logic [CFG_W-1:0]   kern;
    logic [CFG_W-1:0]   msk;
    logic [KSIZE_W-1:0] ks;
    logic [EXT_W-1:0]   ext [3];
    int                 sel;
    kern = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       kern = '0;
      1:       kern = '1;
      default: ;
    endcase
    msk = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1:    msk = '1;
      2:       msk = '0;
      3, 4:    msk = msk & {$urandom, $urandom} & {$urandom, $urandom};
      default: ;
    endcase
    case ($urandom_range(0, 11))
      0:       ks = 3'd0;
      1:       ks = 3'($urandom_range(5, 7));
      default: ks = 3'($urandom_range(1, 4));
    endcase
    for (int ax = 0; ax < 3; ax++) begin
      sel = $urandom_range(0, 39);
      if (sel == 0)      ext[ax] = 6'd0;
      else if (sel < 5)  ext[ax] = 6'($urandom_range(33, 63));
      else if (sel < 13) ext[ax] = 6'd32;
      else               ext[ax] = 6'($urandom_range(1, 8));
    end
    apply_cfg(kern, msk, ks, ($urandom_range(0, 1) == 1) ? MODE_ANY : MODE_ALL,
              ($urandom_range(0, 1) == 1) ? GRAY_ON : GRAY_OFF, ext[0], ext[1], ext[2]);
  endtask

  initial begin
    #30_000_000;
    $display("** volume_morphology_window_match_core: FAILED **");
    $finish;
  end

  initial begin
    idle_pct = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: corner voxels, value extremes
    idle_pct = 20;
    apply_cfg('1, '1, 3'd2, MODE_ALL, GRAY_OFF, 6'd32, 6'd32, 6'd32);
    push_write(0, 0, 0, 8'h01);
    push_query(0, 0, 0);
    push_write(0, 0, 0, 8'hff);
    push_query(0, 0, 0);
    push_write(31, 31, 31, 8'h00);
    push_query(31, 31, 31);
    settle_block();

    // empty support in both modes, gray output
    set_reg(REG_KERNEL_SIZE, 64'd3);
    set_reg(REG_KERNEL_BITS, '0);
    set_reg(REG_MASK_BITS, '0);
    set_reg(REG_COMBINE_MODE, 64'(MODE_ANY));
    set_reg(REG_GRAY_OUTPUT, 64'(GRAY_ON));
    push_query(5, 5, 5);
    settle_block();
    set_reg(REG_COMBINE_MODE, 64'(MODE_ALL));
    push_query(5, 5, 5);
    settle_block();
    set_reg(REG_MASK_BITS, '1);
    push_query(1, 1, 1);
    settle_block();

    // out-of-image store must leave the voxel alone
    apply_cfg('1, '1, 3'd1, MODE_ALL, GRAY_OFF, 6'd32, 6'd32, 6'd32);
    push_write(4, 0, 0, 8'h01);
    settle_block();
    set_reg(REG_IMAGE_ROWS, 64'd4);
    push_write(4, 0, 0, 8'h00);
    push_query(4, 0, 0);
    settle_block();
    set_reg(REG_IMAGE_ROWS, 64'd32);
    push_query(4, 0, 0);
    settle_block();
    set_reg(REG_IMAGE_LAYERS, 64'd0);
    push_query(0, 0, 0);
    settle_block();

    // saturating extents and kernel size, zero kernel size
    apply_cfg({$urandom, $urandom}, '1, 3'd7, MODE_ANY, GRAY_ON, 6'd63, 6'd63, 6'd63);
    push_query(31, 31, 31);
    push_query(0, 31, 0);
    settle_block();
    set_reg(REG_KERNEL_SIZE, 64'd0);
    push_query(16, 16, 16);
    settle_block();

    // random: extreme settings first
    apply_cfg('1, '1, 3'd4, MODE_ALL, GRAY_ON, 6'd32, 6'd32, 6'd32);
    idle_pct = 25;
    run_items(100);
    apply_cfg('0, '1, 3'd1, MODE_ANY, GRAY_OFF, 6'd1, 6'd1, 6'd1);
    idle_pct = 0;
    run_items(100);
    apply_cfg({$urandom, $urandom}, {$urandom, $urandom}, 3'd4, MODE_ANY, GRAY_OFF,
              6'd63, 6'd63, 6'd63);
    idle_pct = 40;
    run_items(100);
    for (int ph = 0; ph < 11; ph++) begin
      idle_pct = (ph == 10) ? 0 : (ph % 4) * 12;
      random_cfg();
      run_items(120);
    end

    $display("%0d voxel transactions (%0d window fills), %0d morphology results (%0d true)",
             txn_cnt, fill_cnt, res_cnt, true_cnt);
    $display("%0d register writes, %0d mismatches", cfg_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("** volume_morphology_window_match_core: PASSED **");
    end else begin
      $display("** volume_morphology_window_match_core: FAILED **");
    end
    $finish;
  end

endmodule
